>>> sv/pcxr_pkg.sv
package pcxr_pkg;

  localparam int RowBytesWidth = 16;
  localparam int RowTotalWidth = 17;
  localparam int CfgDataWidth  = 17;
  localparam int CfgIndexWidth = 2;
  localparam int CountWidth    = 6;

  // Register indexes on the configuration port.
  localparam logic [CfgIndexWidth-1:0] REG_ROW_BYTES = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_ROW_TOTAL = 2'd1;

  // Result kinds.
  localparam logic [1:0] KIND_PIXEL   = 2'd0;
  localparam logic [1:0] KIND_JUNK    = 2'd1;
  localparam logic [1:0] KIND_TRUNC   = 2'd2;

  localparam logic [7:0] MARK_BITS  = 8'hC0;
  localparam logic [7:0] COUNT_MASK = 8'h3F;

  // Status of the row and column position unit.
  typedef struct packed {
    logic full;
    logic row_end;
  } pcxr_pos_t;

endpackage

>>> sv/pcxr_pos.sv
module pcxr_pos (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [pcxr_pkg::RowBytesWidth-1:0]   row_bytes,
  input  logic [pcxr_pkg::RowTotalWidth-1:0]   row_total,
  input  logic                                 step,
  output pcxr_pkg::pcxr_pos_t                  status
);

  logic [pcxr_pkg::RowBytesWidth-1:0] column_index;
  logic [pcxr_pkg::RowTotalWidth-1:0] row_index;
  logic [pcxr_pkg::RowBytesWidth-1:0] column_inc;

  // The column counter wraps at 16 bits, so a zero row length means 65536 bytes.
  assign column_inc     = column_index + pcxr_pkg::RowBytesWidth'(1);
  assign status.full    = (row_index >= row_total);
  assign status.row_end = (column_inc == row_bytes);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      row_index    <= '0;
    end else if (step && !status.full) begin
      if (status.row_end) begin
        column_index <= '0;
        row_index    <= row_index + pcxr_pkg::RowTotalWidth'(1);
      end else begin
        column_index <= column_inc;
      end
    end
  end

endmodule

>>> sv/pcx_rle_row_decoder_top.sv
// A literal byte gives its pixel word from the output register, one byte per cycle while no
// run is under way and the output is not stalled. A run value byte starts a run of N pixels,
// one per cycle from the output register while it is not stalled; the input is stalled until the run is done.
// A stall on the output channel stalls the input as well. Marker bytes give no output.
// Synchronous reset clears the run, position and done state and sets both
// configuration registers to 1.
module pcx_rle_row_decoder_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pcxr_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [pcxr_pkg::CfgDataWidth-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          data_byte,
  input  logic                                stream_end,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          pixel,
  output logic [1:0]                          kind,
  output logic                                row_end,
  output logic                                last
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t state;
  state_t state_next;

  logic [pcxr_pkg::RowBytesWidth-1:0] row_bytes;
  logic [pcxr_pkg::RowTotalWidth-1:0] row_total;

  logic                             run_pending;
  logic                             run_pending_next;
  logic [pcxr_pkg::CountWidth-1:0]  run_count;
  logic [pcxr_pkg::CountWidth-1:0]  run_count_next;
  logic [pcxr_pkg::CountWidth-1:0]  run_left;
  logic [pcxr_pkg::CountWidth-1:0]  run_left_next;
  logic [7:0]                       run_value;
  logic [7:0]                       run_value_next;
  logic                             image_done;
  logic                             image_done_next;

  logic                             out_free;
  logic                             accept;
  logic                             emit_pixel;
  logic                             emit_trunc;
  logic [7:0]                       emit_value;
  logic [pcxr_pkg::CountWidth-1:0]  emit_rem;
  logic                             pos_step;
  pcxr_pkg::pcxr_pos_t              pos;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  pcxr_pos u_pos (
    .clk       (clk),
    .rst       (rst),
    .row_bytes (row_bytes),
    .row_total (row_total),
    .step      (pos_step),
    .status    (pos)
  );

  always_comb begin
    state_next       = state;
    run_pending_next = run_pending;
    run_count_next   = run_count;
    run_left_next    = run_left;
    run_value_next   = run_value;
    image_done_next  = image_done;
    emit_pixel       = 1'b0;
    emit_trunc       = 1'b0;
    emit_value       = data_byte;
    emit_rem         = run_count;
    pos_step         = 1'b0;

    if (state == S_RUN) begin
      if (out_free) begin
        emit_pixel = 1'b1;
        emit_value = run_value;
        emit_rem   = run_left;
      end
    end else if (accept && !image_done) begin
      if (stream_end) begin
        if (run_pending) begin
          run_pending_next = 1'b0;
          emit_trunc       = 1'b1;
        end
      end else if (run_pending) begin
        run_pending_next = 1'b0;
        emit_pixel       = (run_count != '0);
        emit_rem         = run_count;
      end else if ((data_byte & pcxr_pkg::MARK_BITS) == pcxr_pkg::MARK_BITS) begin
        run_pending_next = 1'b1;
        run_count_next   = pcxr_pkg::CountWidth'(data_byte & pcxr_pkg::COUNT_MASK);
      end else begin
        emit_pixel = 1'b1;
        emit_rem   = pcxr_pkg::CountWidth'(1);
      end
    end

    // One pixel through the shared position unit; the junk warning ends the run.
    if (emit_pixel) begin
      if (pos.full) begin
        image_done_next = 1'b1;
        state_next      = S_IDLE;
      end else begin
        pos_step       = 1'b1;
        run_value_next = emit_value;
        run_left_next  = emit_rem - pcxr_pkg::CountWidth'(1);
        state_next     = (emit_rem == pcxr_pkg::CountWidth'(1)) ? S_IDLE : S_RUN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      row_bytes   <= pcxr_pkg::RowBytesWidth'(1);
      row_total   <= pcxr_pkg::RowTotalWidth'(1);
      run_pending <= 1'b0;
      run_count   <= '0;
      image_done  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      run_pending <= run_pending_next;
      run_count   <= run_count_next;
      image_done  <= image_done_next;
      run_left    <= run_left_next;
      run_value   <= run_value_next;
      if (cfg_write) begin
        if (cfg_index == pcxr_pkg::REG_ROW_BYTES) begin
          row_bytes <= cfg_data[pcxr_pkg::RowBytesWidth-1:0];
        end else if (cfg_index == pcxr_pkg::REG_ROW_TOTAL) begin
          row_total <= cfg_data[pcxr_pkg::RowTotalWidth-1:0];
        end
      end
      if (emit_pixel || emit_trunc) begin
        out_valid <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
      if (emit_trunc) begin
        pixel   <= 8'd0;
        kind    <= pcxr_pkg::KIND_TRUNC;
        row_end <= 1'b0;
        last    <= 1'b1;
      end else if (emit_pixel) begin
        if (pos.full) begin
          pixel   <= 8'd0;
          kind    <= pcxr_pkg::KIND_JUNK;
          row_end <= 1'b0;
          last    <= 1'b1;
        end else begin
          pixel   <= ~emit_value;
          kind    <= pcxr_pkg::KIND_PIXEL;
          row_end <= pos.row_end;
          last    <= (emit_rem == pcxr_pkg::CountWidth'(1));
        end
      end
    end
  end

endmodule
